@@ rtl/core/lnws_pkg.sv @@
// lnws_pkg: shared types, constants and small lookup functions for the
// LCD nibble write sequencer. No dependencies.
`default_nettype none

package lnws_pkg;

    // Operation codes carried on s_tuser
    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_INSTR = 2'd1;
    localparam logic [1:0] OP_DATA  = 2'd2;
    localparam logic [1:0] OP_LIGHT = 2'd3;

    // Configuration register indexes
    localparam logic CFG_DELAY_BUS     = 1'b0;
    localparam logic CFG_HAS_BACKLIGHT = 1'b1;

    // Result field widths
    localparam int unsigned BEFORE_W = 14;
    localparam int unsigned AFTER_W  = 6;
    localparam int unsigned BEFORE_MAX = (1 << BEFORE_W) - 1;
    localparam int unsigned AFTER_MAX  = (1 << AFTER_W) - 1;

    // Timing (microseconds)
    localparam int unsigned SETTLE_US       = 40;
    localparam int unsigned POWERUP_WAIT_US = 15000;

    localparam logic [BEFORE_W-1:0] WAIT_POWERUP = BEFORE_W'(
        (POWERUP_WAIT_US > BEFORE_MAX) ? BEFORE_MAX : POWERUP_WAIT_US);
    localparam logic [BEFORE_W-1:0] WAIT_5MS = BEFORE_W'(5000);
    localparam logic [BEFORE_W-1:0] WAIT_1MS = BEFORE_W'(1000);
    localparam logic [AFTER_W-1:0]  WAIT_SETTLE = AFTER_W'(
        (SETTLE_US > AFTER_MAX) ? AFTER_MAX : SETTLE_US);

    // Init nibbles
    localparam logic [3:0] NIB_WAKE   = 4'h3;
    localparam logic [3:0] NIB_4BIT   = 4'h2;
    localparam logic [3:0] LONE_NIBS  = 4'd4;   // wake x3 plus 4-bit switch
    localparam logic [3:0] LAST_NIB_INIT = 4'd11;
    localparam logic [3:0] LAST_NIB_BYTE = 4'd1;

    // Write phases inside one nibble
    localparam logic [1:0] PH_SETUP  = 2'd0;
    localparam logic [1:0] PH_STROBE = 2'd1;
    localparam logic [1:0] PH_HOLD   = 2'd2;

    // Command queue
    localparam int unsigned FIFO_DEPTH = 2;

    typedef struct packed {
        logic [1:0] op;        // operation code
        logic       rs;        // register select for byte writes
        logic [3:0] last_nib;  // index of final nibble
        logic [7:0] data;      // byte to send
        logic       req;       // backlight request
    } cmd_t;

    // Setup bytes sent after the 4-bit switch
    function automatic logic [7:0] setup_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0: b = 8'h28;   // function set, two lines
            2'd1: b = 8'h08;   // display off
            2'd2: b = 8'h01;   // clear
            2'd3: b = 8'h06;   // entry mode, increment
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Wait before each of the lone init nibbles
    function automatic logic [BEFORE_W-1:0] lone_wait(input logic [1:0] nib);
        logic [BEFORE_W-1:0] w;
        unique case (nib)
            2'd0: w = WAIT_POWERUP;
            2'd1: w = WAIT_5MS;
            2'd2: w = WAIT_1MS;
            2'd3: w = '0;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/lnws_front.sv @@
// lnws_front: accepts input transactions and classifies them into commands.
// Depends on lnws_pkg.
`default_nettype none

module lnws_front
    import lnws_pkg::*;
(
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] byte_value, [8] backlight_request
    input  wire logic [1:0]  s_tuser,   // [1:0] operation
    input  wire logic        fifo_full,
    output logic             push,
    output cmd_t             push_cmd
);

    assign s_tready = !fifo_full;
    assign push     = s_tvalid && !fifo_full;

    always_comb
    begin
        push_cmd.op   = s_tuser;
        push_cmd.data = s_tdata[7:0];
        push_cmd.req  = s_tdata[8];
        push_cmd.rs   = (s_tuser == OP_DATA);
        unique case (s_tuser)
            OP_INIT:  push_cmd.last_nib = LAST_NIB_INIT;
            OP_INSTR: push_cmd.last_nib = LAST_NIB_BYTE;
            OP_DATA:  push_cmd.last_nib = LAST_NIB_BYTE;
            OP_LIGHT: push_cmd.last_nib = '0;
            default:  push_cmd.last_nib = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/lnws_cmd_fifo.sv @@
// lnws_cmd_fifo: short command queue between front and back ends.
// Depends on lnws_pkg (cmd_t, FIFO_DEPTH).
`default_nettype none

module lnws_cmd_fifo
    import lnws_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      push_cmd,
    input  wire logic pop,
    output logic      head_valid,
    output cmd_t      head_cmd,
    output logic      full
);

    localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

    cmd_t             mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CNT_W'(FIFO_DEPTH));
    assign head_cmd   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/lnws_back.sv @@
// lnws_back: expands queued commands into LCD port writes, one per cycle while the
// receiver accepts; holds backlight and port shadow state. Depends on lnws_pkg.
`default_nettype none

module lnws_back
    import lnws_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        head_valid,
    input  cmd_t             head_cmd,
    output logic             pop,
    input  wire logic        delay_bus,
    input  wire logic        has_backlight,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [7:0] port_value, [21:8] wait_before_us,
                                        // [27:22] wait_after_us, [31:28] zero
    output logic             m_tlast    // last_write
);

    logic [1:0]          phase_reg, phase_next;
    logic [3:0]          nib_reg, nib_next;
    logic                light_reg, light_next;
    logic [7:0]          shadow_reg, shadow_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_port_reg;
    logic [BEFORE_W-1:0] out_before_reg;
    logic [AFTER_W-1:0]  out_after_reg;
    logic                out_last_reg;

    logic                load;
    logic                is_light;
    logic                is_lone;
    logic                hi_half;
    logic [2:0]          setup_idx;
    logic [7:0]          cur_byte;
    logic [3:0]          cur_nib;
    logic                new_light;
    logic [7:0]          port_w;
    logic [BEFORE_W-1:0] before_w;
    logic [AFTER_W-1:0]  after_w;
    logic                last_w;

    assign load = head_valid && (!out_valid_reg || m_tready);

    always_comb
    begin
        is_light  = (head_cmd.op == OP_LIGHT);
        is_lone   = (head_cmd.op == OP_INIT) && (nib_reg < LONE_NIBS);
        hi_half   = !nib_reg[0];
        setup_idx = nib_reg[3:1] - 3'd2;
        cur_byte  = (head_cmd.op == OP_INIT) ? setup_byte(setup_idx[1:0]) : head_cmd.data;
        cur_nib   = hi_half ? cur_byte[7:4] : cur_byte[3:0];
        new_light = has_backlight && head_cmd.req;

        if (is_light)
        begin
            port_w   = {new_light, shadow_reg[6:0]};
            before_w = '0;
            after_w  = '0;
            last_w   = 1'b1;
        end
        else
        begin
            if (is_lone)
            begin
                port_w = {3'b000, (phase_reg == PH_STROBE),
                          (nib_reg == 4'd3) ? NIB_4BIT : NIB_WAKE};
            end
            else
            begin
                port_w = {light_reg, head_cmd.rs, 1'b0, (phase_reg == PH_STROBE), cur_nib};
            end
            before_w = (is_lone && phase_reg == PH_SETUP) ? lone_wait(nib_reg[1:0]) : '0;
            after_w  = (phase_reg == PH_HOLD) ? WAIT_SETTLE : {{(AFTER_W-1){1'b0}}, delay_bus};
            last_w   = (phase_reg == PH_HOLD) && (nib_reg == head_cmd.last_nib);
        end
    end

    assign pop = load && last_w;

    always_comb
    begin
        phase_next     = phase_reg;
        nib_next       = nib_reg;
        light_next     = light_reg;
        shadow_next    = shadow_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
            shadow_next    = port_w;
            if (is_light)
            begin
                light_next = new_light;
            end
            if (last_w)
            begin
                phase_next = PH_SETUP;
                nib_next   = '0;
            end
            else if (phase_reg == PH_HOLD)
            begin
                phase_next = PH_SETUP;
                nib_next   = nib_reg + 4'd1;
            end
            else
            begin
                phase_next = phase_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SETUP;
            nib_reg       <= '0;
            light_reg     <= 1'b1;
            shadow_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            nib_reg       <= nib_next;
            light_reg     <= light_next;
            shadow_reg    <= shadow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_port_reg   <= port_w;
            out_before_reg <= before_w;
            out_after_reg  <= after_w;
            out_last_reg   <= last_w;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_after_reg, out_before_reg, out_port_reg};
    assign m_tlast  = out_last_reg;

    // Phase counter only walks setup, strobe, hold
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("nibble phase out of range");

    // Byte commands never get past their second nibble
    a_byte_nibs: assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid && (head_cmd.op == OP_INSTR || head_cmd.op == OP_DATA)) |-> nib_reg <= 4'd1)
        else $error("byte command nibble index overrun");

    // Counters are parked at zero whenever a command retires
    a_retire_reset: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (phase_reg == PH_SETUP && nib_reg == 4'd0))
        else $error("sequencer counters not cleared at command end");

    // Bit 5 of the port is never driven
    a_bit5_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[5])
        else $error("unused port bit set");

endmodule

`default_nettype wire

@@ rtl/core/lcd_nibble_write_sequencer.sv @@
// lcd_nibble_write_sequencer: top level, configuration registers and wiring
// of front end, command queue and back end. Depends on lnws_pkg and submodules.
//
// Usage:
//  - s_* channel: one transaction per command. s_tuser = operation (init,
//    instruction byte, data byte, backlight); s_tdata carries the byte and
//    the backlight request.
//  - m_* channel: one transaction per LCD port write with its wait before and
//    after; m_tlast marks the final write of a command.
//  - cfg_*: write-only register port (delay_bus, has_backlight); write only
//    while the block is idle.
//  - A taken command is stored in the command queue, then its first port write
//    is registered in the output register. Throughput: one port write per cycle
//    while the receiver accepts; a nibble is a setup, strobe and hold write.
//  - A two-entry command queue lets new commands in while the back end works;
//    s_tready drops only when both entries are waiting.
//  - Receiver stall: the output register holds its write, the back end
//    pauses, and the queue fills before the input side stalls.
//  - Reset: queue empty, both config bits 1, backlight bit on, port shadow 0.
`default_nettype none

module lcd_nibble_write_sequencer
    import lnws_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // command stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] byte_value, [8] backlight_request
    input  wire logic [1:0]  s_tuser,   // [1:0] operation
    // port write stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [7:0] port_value, [21:8] wait_before_us,
                                        // [27:22] wait_after_us
    output logic             m_tlast,   // last_write
    // configuration
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic        cfg_data
);

    logic delay_bus_reg, delay_bus_next;
    logic has_bl_reg, has_bl_next;

    logic fifo_full;
    logic push;
    cmd_t push_cmd;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    // Config register file
    always_comb
    begin
        delay_bus_next = delay_bus_reg;
        has_bl_next    = has_bl_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DELAY_BUS:     delay_bus_next = cfg_data;
                CFG_HAS_BACKLIGHT: has_bl_next    = cfg_data;
                default:           delay_bus_next = delay_bus_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_bus_reg <= 1'b1;
            has_bl_reg    <= 1'b1;
        end
        else
        begin
            delay_bus_reg <= delay_bus_next;
            has_bl_reg    <= has_bl_next;
        end
    end

    lnws_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .fifo_full (fifo_full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    lnws_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .full       (fifo_full)
    );

    lnws_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_cmd      (head_cmd),
        .pop           (pop),
        .delay_bus     (delay_bus_reg),
        .has_backlight (has_bl_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast)
    );

endmodule

`default_nettype wire
